@@ rtl/lsue_pkg.sv @@
package lsue_pkg;

  localparam int DATA_W      = 32;
  localparam int ROW_W       = 6;
  localparam int COL_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS        = 2'd3;

  localparam logic [DATA_W-1:0] INV_SPACING_RST = 32'd65536;
  localparam logic [DATA_W-1:0] TIME_STEP_RST   = 32'd6554;
  localparam logic [ROW_W-1:0]  ROWS_RST        = 6'd32;
  localparam logic [COL_W-1:0]  COLS_RST        = 16'd2;

  // one grid point on its way from the front end to the update engine
  typedef struct packed {
    logic signed [DATA_W-1:0] field;
    logic signed [DATA_W-1:0] refv;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic [ROW_W-1:0]         rows;
    logic [COL_W-1:0]         cols;
    logic                     last;
  } job_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RD,
    B_MUL,
    B_NORM,
    B_SQ,
    B_SQRT,
    B_DIV,
    B_HMUL,
    B_TS,
    B_OUT,
    B_WR
  } back_state_t;

endpackage

@@ rtl/lsue_ram.sv @@
module lsue_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/lsue_front.sv @@
module lsue_front import lsue_pkg::*; #(
  parameter int MAX_ROWS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic signed [DATA_W-1:0] in_field_value,
  input  logic signed [DATA_W-1:0] in_reference_value,
  input  logic [ROW_W-1:0]         rows_in_use,
  input  logic [COL_W-1:0]         columns_in_use,
  input  logic                     q_full,
  output logic                     in_stall,
  output logic                     q_push,
  output job_t                     q_job
);

  localparam logic [ROW_W-1:0] ROWS_MAX = ROW_W'(MAX_ROWS);

  logic [ROW_W-1:0] row_r, row_nxt, rows_eff, row_cur;
  logic [COL_W-1:0] col_r, col_nxt, cols_eff, col_cur;
  logic             restart, row_end, last;

  always_comb begin
    priority if (rows_in_use < ROW_W'(2)) begin
      rows_eff = ROW_W'(2);
    end else if (rows_in_use > ROWS_MAX) begin
      rows_eff = ROWS_MAX;
    end else begin
      rows_eff = rows_in_use;
    end
    cols_eff = (columns_in_use < COL_W'(2)) ? COL_W'(2) : columns_in_use;

    // counters outside the grid start a new grid
    restart = (row_r >= rows_eff) || (col_r >= cols_eff);
    row_cur = restart ? '0 : row_r;
    col_cur = restart ? '0 : col_r;
    row_end = (row_cur == rows_eff - ROW_W'(1));
    last    = row_end && (col_cur == cols_eff - COL_W'(1));

    priority if (last) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (row_end) begin
      row_nxt = '0;
      col_nxt = col_cur + COL_W'(1);
    end else begin
      row_nxt = row_cur + ROW_W'(1);
      col_nxt = col_cur;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_job.field = in_field_value;
    q_job.refv  = in_reference_value;
    q_job.row   = row_cur;
    q_job.col   = col_cur;
    q_job.rows  = rows_eff;
    q_job.cols  = cols_eff;
    q_job.last  = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (q_push) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

@@ rtl/lsue_queue.sv @@
module lsue_queue import lsue_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic q_valid,
  output logic q_full,
  output job_t pop_job
);

  localparam int PW   = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  job_t            slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == CNTW'(QUEUE_DEPTH));
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;
  assign pop_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CNTW'(1);
        2'b01:   cnt_r <= cnt_r - CNTW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ rtl/lsue_back.sv @@
module lsue_back import lsue_pkg::*; #(
  parameter int MAX_ROWS  = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  job_t                     q_job,
  output logic                     q_pop,
  input  logic [DATA_W-1:0]        inv_spacing,
  input  logic [DATA_W-1:0]        time_step,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_updated_value,
  output logic                     out_zero_normal,
  output logic                     out_grid_end
);

  localparam int AW      = $clog2(2 * MAX_ROWS);
  localparam int NW      = 32 + FRAC_BITS;
  localparam int QW      = FRAC_BITS + 1;
  localparam int CW      = $clog2(NW + 1);
  localparam int N_OPS   = 6;
  localparam int RD_LAST = 4;
  localparam int MUL2    = 2;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [32:0] mag33(input logic [32:0] v);
    return v[32] ? (~v + 33'd1) : v;
  endfunction

  function automatic logic [32:0] sub33(input logic [31:0] a, input logic [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

  // saturate a shifted magnitude to signed 32 bits with the given sign
  function automatic logic [31:0] sat_mag(input logic [95:0] s, input logic neg);
    logic [31:0] res;
    if (neg) begin
      res = (s > 96'h8000_0000) ? 32'h8000_0000 : (~s[31:0] + 32'd1);
    end else begin
      res = (s > 96'h7FFF_FFFF) ? 32'h7FFF_FFFF : s[31:0];
    end
    return res;
  endfunction

  function automatic logic [AW-1:0] buf_addr(input logic slot, input logic [ROW_W-1:0] row);
    logic [AW-1:0] base;
    base = slot ? AW'(MAX_ROWS) : '0;
    return base + AW'(row);
  endfunction

  back_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  job_t             job_r;
  logic             flush_r;
  logic [ROW_W-1:0] er_r;
  logic [COL_W-1:0] ec_r;

  logic [31:0] f_c_r, f_u_r, f_d_r, f_l_r, r_c_r, r_u_r, r_d_r, r_l_r;
  logic [31:0] d_r [N_OPS];
  logic [31:0] ax_r, ay_r;
  logic [63:0] sq_r, v_r, res_r, bit_r;
  logic [31:0] rdiv_r;
  logic [NW-1:0] numx_r, numy_r, qx_r, qy_r;
  logic [31:0] remx_r, remy_r;
  logic signed [63:0] h_r;
  logic [64:0] p0_r, mul_p_r;
  logic        mneg_r, mhalf_r;
  logic        zero_r;
  logic [31:0] upd_r;

  logic        out_valid_r;
  logic [31:0] out_upd_r;
  logic        out_zero_r, out_end_r;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [63:0]     ram_wdata, ram_rdata;

  logic        x_first, x_last, y_first, y_last, out_free, zero_now, shift_more;
  logic [32:0] diff_a [N_OPS];
  logic        half_a [N_OPS];
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic        mul_neg, mul_half;
  logic [2:0]  op, cap;
  logic [95:0] mul_shifted;
  logic [31:0] mul_sat;
  logic        sx, sy;
  logic [31:0] dsel_x, dsel_y;
  logic signed [63:0] prod_s, term;
  logic [63:0] hmag, sq_sum;
  logic [95:0] ts_total, ts_shifted;
  logic [31:0] hts;
  logic [32:0] upd_diff;
  logic [31:0] upd_calc;
  logic [32:0] tx, ty;
  logic        gx, gy;

  lsue_ram #(
    .WIDTH (64),
    .DEPTH (2 * MAX_ROWS)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // stencil position and neighbor differences
  always_comb begin
    x_first = (er_r == '0);
    x_last  = (er_r == job_r.rows - ROW_W'(1));
    y_first = (ec_r == '0);
    y_last  = (ec_r == job_r.cols - COL_W'(1));

    diff_a[0] = (x_last && !x_first) ? sub33(f_c_r, f_u_r) : sub33(f_d_r, f_c_r);
    diff_a[1] = x_first ? sub33(f_d_r, f_c_r) : sub33(f_c_r, f_u_r);
    diff_a[2] = x_first ? sub33(r_d_r, r_c_r) :
                x_last  ? sub33(r_c_r, r_u_r) : sub33(r_d_r, r_u_r);
    diff_a[3] = (y_last && !y_first) ? sub33(f_c_r, f_l_r) : sub33(job_r.field, f_c_r);
    diff_a[4] = y_first ? sub33(job_r.field, f_c_r) : sub33(f_c_r, f_l_r);
    diff_a[5] = y_first ? sub33(job_r.refv, r_c_r) :
                y_last  ? sub33(r_c_r, r_l_r) : sub33(job_r.refv, r_l_r);
    half_a[0] = 1'b0;
    half_a[1] = 1'b0;
    half_a[2] = !x_first && !x_last;
    half_a[3] = 1'b0;
    half_a[4] = 1'b0;
    half_a[5] = !y_first && !y_last;
  end

  // arithmetic around the shared multiplier and iterative units
  always_comb begin
    op  = cnt_r[2:0];
    cap = cnt_r[2:0] - 3'd1;
    out_free = !out_valid_r || !out_stall;
    zero_now = (d_r[2] == '0) && (d_r[5] == '0);
    shift_more = (ax_r[31:30] == 2'b00) && (ay_r[31:30] == 2'b00);

    mul_shifted = mhalf_r ? ({31'b0, mul_p_r} >> (FRAC_BITS + 1))
                          : ({31'b0, mul_p_r} >> FRAC_BITS);
    mul_sat = sat_mag(mul_shifted, mneg_r);

    // a component points negative when its sign differs from the reference sign
    sx     = d_r[2][31] ^ r_c_r[31];
    sy     = d_r[5][31] ^ r_c_r[31];
    dsel_x = (!sx && (qx_r != '0)) ? d_r[1] : d_r[0];
    dsel_y = (!sy && (qy_r != '0)) ? d_r[4] : d_r[3];
    prod_s = mul_p_r[63:0];
    term   = mneg_r ? -prod_s : prod_s;

    sq_sum = sq_r + mul_p_r[63:0];

    hmag       = h_r[63] ? 64'(-h_r) : 64'(h_r);
    ts_total   = ({31'b0, mul_p_r} << 32) + {31'b0, p0_r};
    ts_shifted = ts_total >> (2 * FRAC_BITS);
    hts        = sat_mag(ts_shifted, h_r[63]);
    upd_diff   = sub33(f_c_r, hts);
    if (upd_diff[32] != upd_diff[31]) begin
      upd_calc = upd_diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      upd_calc = upd_diff[31:0];
    end

    tx = {remx_r, numx_r[NW-1]};
    ty = {remy_r, numy_r[NW-1]};
    gx = (tx >= {1'b0, rdiv_r});
    gy = (ty >= {1'b0, rdiv_r});
  end

  // multiplier operand selection
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_neg  = 1'b0;
    mul_half = 1'b0;
    unique case (state_r)
      B_MUL: begin
        if (cnt_r < CW'(N_OPS)) begin
          mul_a    = mag33(diff_a[op]);
          mul_b    = inv_spacing;
          mul_neg  = diff_a[op][32];
          mul_half = half_a[op];
        end
      end
      B_SQ: begin
        mul_a = (cnt_r == '0) ? {1'b0, ax_r} : {1'b0, ay_r};
        mul_b = (cnt_r == '0) ? ax_r : ay_r;
      end
      B_HMUL: begin
        if (cnt_r == '0) begin
          mul_a   = 33'(qx_r[QW-1:0]);
          mul_b   = mag32(dsel_x);
          mul_neg = sx ^ dsel_x[31];
        end else begin
          mul_a   = 33'(qy_r[QW-1:0]);
          mul_b   = mag32(dsel_y);
          mul_neg = sy ^ dsel_y[31];
        end
      end
      B_TS: begin
        mul_a = (cnt_r == '0) ? {1'b0, hmag[31:0]} : {1'b0, hmag[63:32]};
        mul_b = time_step;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (q_valid) begin
        state_nxt = (q_job.col != '0) ? B_RD : B_WR;
      end
      B_RD:   if (cnt_r == CW'(RD_LAST)) state_nxt = B_MUL;
      B_MUL:  if (cnt_r == CW'(N_OPS)) state_nxt = B_NORM;
      B_NORM: begin
        if (cnt_r == '0) begin
          if (zero_now) state_nxt = B_OUT;
        end else if (!shift_more) begin
          state_nxt = B_SQ;
        end
      end
      B_SQ:   if (cnt_r == CW'(MUL2)) state_nxt = B_SQRT;
      B_SQRT: if (bit_r == '0) state_nxt = B_DIV;
      B_DIV:  if (cnt_r == CW'(NW)) state_nxt = B_HMUL;
      B_HMUL: if (cnt_r == CW'(MUL2)) state_nxt = B_TS;
      B_TS:   if (cnt_r == CW'(MUL2)) state_nxt = B_OUT;
      B_OUT: begin
        if (out_free) begin
          if (flush_r) begin
            state_nxt = x_last ? B_IDLE : B_RD;
          end else begin
            state_nxt = B_WR;
          end
        end
      end
      B_WR:   state_nxt = job_r.last ? B_RD : B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
    cnt_nxt = (state_nxt != state_r) ? '0 : cnt_r + CW'(1);
  end

  // control outputs
  always_comb begin
    q_pop     = (state_r == B_IDLE) && q_valid;
    ram_we    = (state_r == B_WR);
    ram_waddr = buf_addr(job_r.col[0], job_r.row);
    ram_wdata = {job_r.field, job_r.refv};
    ram_raddr = buf_addr(ec_r[0], er_r);
    if (state_r == B_RD) begin
      unique case (cnt_r)
        CW'(1):  ram_raddr = buf_addr(ec_r[0], x_first ? er_r : er_r - ROW_W'(1));
        CW'(2):  ram_raddr = buf_addr(ec_r[0], x_last ? er_r : er_r + ROW_W'(1));
        CW'(3):  ram_raddr = buf_addr(!ec_r[0], er_r);
        default: ram_raddr = buf_addr(ec_r[0], er_r);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == B_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
    mneg_r  <= mul_neg;
    mhalf_r <= mul_half;

    if (state_r == B_OUT && out_free) begin
      out_upd_r  <= upd_r;
      out_zero_r <= zero_r;
      out_end_r  <= x_last && y_last;
    end

    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          job_r   <= q_job;
          er_r    <= q_job.row;
          ec_r    <= q_job.col - COL_W'(1);
          flush_r <= 1'b0;
        end
      end
      B_RD: begin
        unique case (cnt_r)
          CW'(1): begin
            f_c_r <= ram_rdata[63:32];
            r_c_r <= ram_rdata[31:0];
          end
          CW'(2): begin
            f_u_r <= ram_rdata[63:32];
            r_u_r <= ram_rdata[31:0];
          end
          CW'(3): begin
            f_d_r <= ram_rdata[63:32];
            r_d_r <= ram_rdata[31:0];
          end
          CW'(4): begin
            f_l_r <= ram_rdata[63:32];
            r_l_r <= ram_rdata[31:0];
          end
          default: begin
          end
        endcase
      end
      B_MUL: begin
        if (cnt_r != '0) begin
          d_r[cap] <= mul_sat;
        end
      end
      B_NORM: begin
        if (cnt_r == '0) begin
          ax_r   <= mag32(d_r[2]);
          ay_r   <= mag32(d_r[5]);
          zero_r <= zero_now;
          upd_r  <= f_c_r;
        end else if (shift_more) begin
          ax_r <= {ax_r[30:0], 1'b0};
          ay_r <= {ay_r[30:0], 1'b0};
        end
      end
      B_SQ: begin
        if (cnt_r == CW'(1)) begin
          sq_r <= mul_p_r[63:0];
        end else if (cnt_r == CW'(MUL2)) begin
          v_r   <= sq_sum;
          res_r <= '0;
          bit_r <= 64'h4000_0000_0000_0000;
        end
      end
      B_SQRT: begin
        if (bit_r != '0) begin
          if (v_r >= res_r + bit_r) begin
            v_r   <= v_r - (res_r + bit_r);
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end else begin
          // root done: load both dividers
          rdiv_r <= (res_r == '0) ? 32'd1 : res_r[31:0];
          numx_r <= {ax_r, {FRAC_BITS{1'b0}}};
          numy_r <= {ay_r, {FRAC_BITS{1'b0}}};
          remx_r <= '0;
          remy_r <= '0;
          qx_r   <= '0;
          qy_r   <= '0;
        end
      end
      B_DIV: begin
        if (cnt_r < CW'(NW)) begin
          numx_r <= {numx_r[NW-2:0], 1'b0};
          numy_r <= {numy_r[NW-2:0], 1'b0};
          remx_r <= gx ? 32'(tx - {1'b0, rdiv_r}) : tx[31:0];
          remy_r <= gy ? 32'(ty - {1'b0, rdiv_r}) : ty[31:0];
          qx_r   <= {qx_r[NW-2:0], gx};
          qy_r   <= {qy_r[NW-2:0], gy};
        end
      end
      B_HMUL: begin
        if (cnt_r == CW'(1)) begin
          h_r <= term;
        end else if (cnt_r == CW'(MUL2)) begin
          h_r <= h_r + term;
        end
      end
      B_TS: begin
        if (cnt_r == CW'(1)) begin
          p0_r <= mul_p_r;
        end else if (cnt_r == CW'(MUL2)) begin
          upd_r <= upd_calc;
        end
      end
      B_OUT: begin
        if (out_free && flush_r) begin
          er_r <= er_r + ROW_W'(1);
        end
      end
      B_WR: begin
        // last point of the grid: sweep the final column
        if (job_r.last) begin
          er_r    <= '0;
          ec_r    <= job_r.cols - COL_W'(1);
          flush_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_updated_value = out_upd_r;
  assign out_zero_normal   = out_zero_r;
  assign out_grid_end      = out_end_r;

endmodule

@@ rtl/level_set_upwind_extension_step.sv @@
// Results: a first-column point yields none; every other point yields one result, for the
// point in the same row of the previous column, and the last point of a grid adds one such
// result per row. The update engine works on one point at a time, through the 32-step
// square root and the (32 + FRAC_BITS)-step dividers, and takes the next point when done.
// Reset (rst_n low, synchronous) clears counters, queue and valids; the line buffer
// holds whatever was last written.
module level_set_upwind_extension_step import lsue_pkg::*; #(
  parameter int MAX_ROWS  = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_field_value,
  input  logic signed [DATA_W-1:0] in_reference_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_updated_value,
  output logic                     out_zero_normal,
  output logic                     out_grid_end,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata
);

  logic [DATA_W-1:0] inv_spacing_r, time_step_r;
  logic [ROW_W-1:0]  rows_r;
  logic [COL_W-1:0]  cols_r;

  logic q_push, q_full, q_valid, q_pop;
  job_t push_job, pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_spacing_r <= INV_SPACING_RST;
      time_step_r   <= TIME_STEP_RST;
      rows_r        <= ROWS_RST;
      cols_r        <= COLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INV_SPACING: inv_spacing_r <= cfg_wdata;
        CFG_TIME_STEP:   time_step_r   <= cfg_wdata;
        CFG_ROWS:        rows_r        <= cfg_wdata[ROW_W-1:0];
        CFG_COLS:        cols_r        <= cfg_wdata[COL_W-1:0];
      endcase
    end
  end

  lsue_front #(
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_field_value     (in_field_value),
    .in_reference_value (in_reference_value),
    .rows_in_use        (rows_r),
    .columns_in_use     (cols_r),
    .q_full             (q_full),
    .in_stall           (in_stall),
    .q_push             (q_push),
    .q_job              (push_job)
  );

  lsue_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .pop_job  (pop_job)
  );

  lsue_back #(
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_job             (pop_job),
    .q_pop             (q_pop),
    .inv_spacing       (inv_spacing_r),
    .time_step         (time_step_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_updated_value (out_updated_value),
    .out_zero_normal   (out_zero_normal),
    .out_grid_end      (out_grid_end)
  );

endmodule

@@ bench/testbench.sv @@
module testbench;
  import lsue_pkg::*;

  localparam int FRAC = 16;
  localparam int MAXR = 32;
  localparam int WATCH_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE = 200;

  typedef struct {
    logic signed [DATA_W-1:0] upd;
    logic                     zn;
    logic                     ge;
  } point_result_t;

  typedef struct {
    logic signed [DATA_W-1:0] fv;
    logic signed [DATA_W-1:0] rv;
    bit                       known;
    logic signed [DATA_W-1:0] known_upd;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic signed [DATA_W-1:0] in_field_value, in_reference_value;
  logic out_valid, out_stall;
  logic signed [DATA_W-1:0] out_updated_value;
  logic out_zero_normal, out_grid_end;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_wdata;

  level_set_upwind_extension_step DUT (.*);

  // predictor state
  logic [31:0] p_inv, p_ts;
  logic [5:0]  p_rows;
  logic [15:0] p_cols;
  logic [31:0] fld_buf [0:2*MAXR-1];
  logic [31:0] ref_buf [0:2*MAXR-1];
  int unsigned row_ctr, col_ctr;
  bit cur_live;
  int unsigned cur_row, cur_col;
  logic [31:0] cur_fld, cur_ref;

  point_result_t pending_updates[$];
  int errors, items_sent, results_seen, grids_done;
  bit quiet, hold_req, hold_done;
  int idle_cycles;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // signed a times unsigned b, shift right, truncate toward zero, saturate
  function automatic longint mul_sat(longint a, logic [31:0] b, int sh);
    logic [127:0] prod;
    longint unsigned ua, m;
    bit neg;
    neg = a < 0;
    ua = neg ? longint'(0) - a : a;
    prod = {64'b0, ua} * {96'b0, b};
    prod = prod >> sh;
    m = (prod > 128'h1_0000_0000) ? 64'h1_0000_0000 : prod[63:0];
    if (neg) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return -longint'(m);
    end
    if (m > 64'h7fff_ffff) m = 64'h7fff_ffff;
    return longint'(m);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint grid_val(bit is_ref, int unsigned r, int unsigned c);
    int unsigned idx;
    if (cur_live && r == cur_row && c == cur_col) return sx(is_ref ? cur_ref : cur_fld);
    idx = (c & 1) * MAXR + r;
    if (r >= MAXR) return 0;
    return sx(is_ref ? ref_buf[idx] : fld_buf[idx]);
  endfunction

  function automatic point_result_t update_point(int unsigned i, int unsigned j,
                                                 int unsigned m, int unsigned n);
    point_result_t res;
    longint fc, dxp, dxm, dyp, dym, nx, ny, h, px, py, upd;
    longint unsigned ax, ay, r;
    bit zero, flip;
    h = 0;
    fc = grid_val(0, i, j);
    if (i == 0) begin
      dxp = mul_sat(grid_val(0, 1, j) - fc, p_inv, FRAC);
      dxm = dxp;
      nx = mul_sat(grid_val(1, 1, j) - grid_val(1, 0, j), p_inv, FRAC);
    end else if (i == m - 1) begin
      dxp = mul_sat(fc - grid_val(0, i - 1, j), p_inv, FRAC);
      dxm = dxp;
      nx = mul_sat(grid_val(1, i, j) - grid_val(1, i - 1, j), p_inv, FRAC);
    end else begin
      dxp = mul_sat(grid_val(0, i + 1, j) - fc, p_inv, FRAC);
      dxm = mul_sat(fc - grid_val(0, i - 1, j), p_inv, FRAC);
      nx = mul_sat(grid_val(1, i + 1, j) - grid_val(1, i - 1, j), p_inv, FRAC + 1);
    end
    if (j == 0) begin
      dyp = mul_sat(grid_val(0, i, 1) - fc, p_inv, FRAC);
      dym = dyp;
      ny = mul_sat(grid_val(1, i, 1) - grid_val(1, i, 0), p_inv, FRAC);
    end else if (j == n - 1) begin
      dyp = mul_sat(fc - grid_val(0, i, j - 1), p_inv, FRAC);
      dym = dyp;
      ny = mul_sat(grid_val(1, i, j) - grid_val(1, i, j - 1), p_inv, FRAC);
    end else begin
      dyp = mul_sat(grid_val(0, i, j + 1) - fc, p_inv, FRAC);
      dym = mul_sat(fc - grid_val(0, i, j - 1), p_inv, FRAC);
      ny = mul_sat(grid_val(1, i, j + 1) - grid_val(1, i, j - 1), p_inv, FRAC + 1);
    end
    zero = (nx == 0 && ny == 0);
    if (!zero) begin
      ax = nx < 0 ? -nx : nx;
      ay = ny < 0 ? -ny : ny;
      flip = grid_val(1, i, j) < 0;
      while (ax < 64'h4000_0000 && ay < 64'h4000_0000) begin
        ax = ax << 1;
        ay = ay << 1;
      end
      r = floor_sqrt(ax * ax + ay * ay);
      if (r == 0) r = 1;
      px = longint'((ax << FRAC) / r);
      py = longint'((ay << FRAC) / r);
      if ((nx < 0) != flip) px = -px;
      if ((ny < 0) != flip) py = -py;
      h += (px > 0) ? px * dxm : px * dxp;
      h += (py > 0) ? py * dym : py * dyp;
    end
    upd = fc - mul_sat(h, p_ts, 2 * FRAC);
    if (upd > 64'sh7fff_ffff) upd = 64'sh7fff_ffff;
    if (upd < -64'sh8000_0000) upd = -64'sh8000_0000;
    res.upd = upd[31:0];
    res.zn = zero;
    res.ge = (i == m - 1 && j == n - 1);
    return res;
  endfunction

  // advance the grid model by one accepted point; returns the number of results queued
  function automatic int grid_step(logic [31:0] fv, logic [31:0] rv);
    int unsigned m, n, i, j;
    int cnt;
    m = p_rows;
    n = p_cols;
    cnt = 0;
    if (m < 2) m = 2;
    if (m > MAXR) m = MAXR;
    if (n < 2) n = 2;
    i = row_ctr;
    j = col_ctr;
    if (i >= m || j >= n) begin
      i = 0;
      j = 0;
    end
    cur_live = 1;
    cur_row = i;
    cur_col = j;
    cur_fld = fv;
    cur_ref = rv;
    if (j >= 1) begin
      pending_updates.push_back(update_point(i, j - 1, m, n));
      cnt++;
    end
    fld_buf[(j & 1) * MAXR + i] = fv;
    ref_buf[(j & 1) * MAXR + i] = rv;
    cur_live = 0;
    if (i == m - 1 && j == n - 1) begin
      for (int k = 0; k < m; k++) begin
        pending_updates.push_back(update_point(k, n - 1, m, n));
        cnt++;
      end
      row_ctr = 0;
      col_ctr = 0;
      grids_done++;
    end else if (i + 1 >= m) begin
      row_ctr = 0;
      col_ctr = (j + 1) & 16'hffff;
    end else begin
      row_ctr = i + 1;
      col_ctr = j;
    end
    return cnt;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_INV_SPACING: p_inv = val;
      CFG_TIME_STEP:   p_ts = val;
      CFG_ROWS:        p_rows = val[5:0];
      CFG_COLS:        p_cols = val[15:0];
    endcase
  endtask

  task automatic set_grid(logic [31:0] inv, logic [31:0] ts, logic [5:0] rows,
                          logic [15:0] cols);
    write_reg(CFG_INV_SPACING, inv);
    write_reg(CFG_TIME_STEP, ts);
    write_reg(CFG_ROWS, 32'(rows));
    write_reg(CFG_COLS, 32'(cols));
  endtask

  task automatic drain();
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  // wait for all results, then let a point that yields none leave the pipeline
  task automatic settle();
    drain();
    repeat (SETTLE) @(posedge clk);
  endtask

  // send one point; when known, the first result it causes is typed in
  task automatic send_point(logic [31:0] fv, logic [31:0] rv, bit known,
                            logic [31:0] known_upd);
    int gap, before_cnt, n;
    gap = (quiet || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_field_value <= fv;
    in_reference_value <= rv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    before_cnt = pending_updates.size();
    n = grid_step(fv, rv);
    if (known && n > 0) begin
      pending_updates[before_cnt].upd = known_upd;
      pending_updates[before_cnt].zn = 1'b1;
    end
    items_sent++;
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value(int style, logic [31:0] base);
    if (style == 0) return $urandom;
    return base + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
  endfunction

  stim_row_t directed [0:24];

  task automatic run_directed(int first, int count);
    for (int k = first; k < first + count; k++)
      send_point(directed[k].fv, directed[k].rv, directed[k].known, directed[k].known_upd);
    end_burst();
    settle();
  endtask

  initial begin
    int style, m, n, gridc, passes;
    logic [31:0] base;
    logic [5:0] rows;
    logic [15:0] cols;
    logic [31:0] inv;

    rst_n = 1'b0;
    in_valid <= 1'b0;
    in_field_value <= '0;
    in_reference_value <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_INV_SPACING;
    cfg_wdata <= '0;
    p_inv = INV_SPACING_RST;
    p_ts = TIME_STEP_RST;
    p_rows = ROWS_RST;
    p_cols = COLS_RST;
    row_ctr = 0;
    col_ctr = 0;
    cur_live = 0;
    for (int k = 0; k < 2 * MAXR; k++) begin
      fld_buf[k] = '0;
      ref_buf[k] = '0;
    end

    // zero spacing: every point passes through with a zero normal
    directed[0] = '{32'sh7fff_ffff, 32'sh8000_0000, 0, 0};
    directed[1] = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 0};
    directed[2] = '{32'sh0000_0000, 32'sh0000_0000, 1, 32'sh7fff_ffff};
    directed[3] = '{-32'sd1, 32'sd1, 1, 32'sh8000_0000};
    // largest spacing and step: saturation everywhere
    directed[4] = '{32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0};
    directed[5] = '{32'sh8000_0000, 32'sh8000_0000, 0, 0};
    directed[6] = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 0};
    directed[7] = '{32'sh7fff_ffff, 32'sh8000_0000, 0, 0};
    directed[8] = '{32'sh0000_0000, -32'sd1, 0, 0};
    directed[9] = '{32'sh5555_5555, 32'sh0000_0000, 0, 0};
    // 3x3 with an interior point, zero reference counted as positive
    directed[10] = '{32'sh0001_0000, 32'sh0000_0000, 0, 0};
    directed[11] = '{32'sh0002_0000, 32'sh0000_0000, 0, 0};
    directed[12] = '{32'sh0003_0000, -32'sh0001_0000, 0, 0};
    directed[13] = '{32'sh0000_8000, 32'sh0000_0000, 0, 0};
    directed[14] = '{-32'sh0002_0000, 32'sh0000_0000, 0, 0};
    directed[15] = '{32'sh0000_4000, 32'sh0001_0000, 0, 0};
    directed[16] = '{32'sh0004_0000, 32'sh0002_0000, 0, 0};
    directed[17] = '{32'sh2aaa_aaaa, -32'sh0003_0000, 0, 0};
    directed[18] = '{32'sh0000_0001, 32'sh0000_0001, 0, 0};
    // widest column count: only the first columns of a huge grid
    directed[19] = '{32'sh1234_5678, 32'sh0fed_cba9, 0, 0};
    directed[20] = '{32'shedcb_a987, -32'sh0fed_cba9, 0, 0};
    directed[21] = '{32'sh0000_ffff, 32'sh0001_0000, 0, 0};
    directed[22] = '{32'shffff_0000, 32'sh0000_0000, 0, 0};
    directed[23] = '{32'sh0f0f_0f0f, 32'shf0f0_f0f0, 0, 0};
    directed[24] = '{32'sh3333_3333, 32'shcccc_cccc, 0, 0};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_grid(32'd0, 32'hffff_ffff, 6'd0, 16'd1);
    run_directed(0, 4);
    set_grid(32'hffff_ffff, 32'hffff_ffff, 6'd2, 16'd3);
    run_directed(4, 6);
    set_grid(INV_SPACING_RST, TIME_STEP_RST, 6'd3, 16'd3);
    run_directed(10, 9);
    set_grid(32'd1, 32'd0, 6'd2, 16'hffff);
    run_directed(19, 6);

    gridc = 0;
    while (items_sent < 140) begin
      if (items_sent > 120) quiet = 1;
      case ($urandom_range(0, 3))
        0: inv = INV_SPACING_RST;
        1: inv = $urandom_range(1, 32'h0010_0000);
        2: inv = $urandom;
        default: inv = 32'd1 << $urandom_range(0, 31);
      endcase
      case ($urandom_range(0, 9))
        0: rows = 6'd32;
        1: rows = 6'd63;
        2: rows = $urandom_range(0, 1);
        default: rows = $urandom_range(2, 6);
      endcase
      cols = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 1))
                                         : 16'($urandom_range(2, 4));
      // the huge grid above stopped at column 3: restart cleanly
      if (gridc == 0) begin
        cols = 16'd2;
        // tall enough that the held-off output backs up into the input
        rows = 6'd6;
      end
      m = rows < 2 ? 2 : (rows > MAXR ? MAXR : rows);
      n = cols < 2 ? 2 : cols;
      passes = ($urandom_range(0, 2) == 0) ? 2 : 1;
      // keep the run near its item budget
      if (items_sent + passes * m * n > 170) passes = 1;
      if (items_sent + m * n > 170) begin
        cols = 16'd2;
        n = 2;
      end
      if (items_sent + m * n > 170) begin
        rows = 6'd2;
        m = 2;
      end
      set_grid(inv, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0002_0000),
               rows, cols);
      if (gridc == 0) hold_req = 1;
      for (int g = 0; g < passes; g++) begin
        style = $urandom_range(0, 2);
        base = $urandom;
        for (int k = 0; k < m * n; k++) begin
          if (gridc == 1 && g == 0 && k == m) begin
            end_burst();
            drain();
          end
          send_point(rand_value(style, base), rand_value(style == 0 ? 0 : 1, base), 0, 0);
        end
      end
      end_burst();
      settle();
      gridc++;
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (pending_updates.size() != 0) begin
      $error("%0d results never arrived", pending_updates.size());
      errors++;
    end
    $display("Covered %0d points in %0d grids, %0d updates checked, incl. saturation,",
             items_sent, grids_done, results_seen);
    $display("zero normals, clamped sizes, long output hold-off and drained pauses.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    int burst, hold;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        out_stall <= 1'b1;
        for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // compare each transfer against the oldest expected update
  always @(posedge clk) begin
    point_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_updates.size() == 0) begin
        $error("unexpected result: updated_value %h", out_updated_value);
        errors++;
      end else begin
        want = pending_updates.pop_front();
        if (out_updated_value !== want.upd) begin
          $error("updated_value: expected %h, got %h", want.upd, out_updated_value);
          errors++;
        end
        if (out_zero_normal !== want.zn) begin
          $error("zero_normal: expected %b, got %b", want.zn, out_zero_normal);
          errors++;
        end
        if (out_grid_end !== want.ge) begin
          $error("grid_end: expected %b, got %b", want.ge, out_grid_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ level_set_upwind_extension_step.f @@
rtl/lsue_pkg.sv
rtl/lsue_ram.sv
rtl/lsue_front.sv
rtl/lsue_queue.sv
rtl/lsue_back.sv
rtl/level_set_upwind_extension_step.sv
bench/testbench.sv
